### hw/rtl/key_button_event_tracker_core_assert.svh
// Assertion macros used by the checker module of the event tracker.
`ifndef KEY_BUTTON_EVENT_TRACKER_CORE_ASSERT_SVH
`define KEY_BUTTON_EVENT_TRACKER_CORE_ASSERT_SVH

// The consequent must hold at the same edge as the antecedent.
`define KBET_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kbet assertion failed");

// The consequent must hold at the edge after the antecedent.
`define KBET_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kbet assertion failed");

`endif

### hw/rtl/kbet_pkg.sv
package kbet_pkg;

  localparam int KEY_COUNT_DEF    = 512;
  localparam int BUTTON_COUNT_DEF = 8;
  localparam int CODE_W           = 21;
  localparam int CFG_IDX_W        = 3;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_KEY    = 2'd0;
  localparam kind_t KIND_CHAR   = 2'd1;
  localparam kind_t KIND_BUTTON = 2'd2;
  localparam kind_t KIND_CLEAR  = 2'd3;

  typedef logic [1:0] kstate_t;
  localparam kstate_t ST_RELEASED = 2'd0;
  localparam kstate_t ST_PRESSED  = 2'd1;
  localparam kstate_t ST_STUCK    = 2'd2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_STICKY_KEYS    = 3'd0;
  localparam cfg_idx_t CFG_STICKY_BUTTONS = 3'd1;
  localparam cfg_idx_t CFG_REPEAT_ENABLE  = 3'd2;
  localparam cfg_idx_t CFG_KEY_REPORT     = 3'd3;
  localparam cfg_idx_t CFG_CHAR_REPORT    = 3'd4;
  localparam cfg_idx_t CFG_BUTTON_REPORT  = 3'd5;

  typedef logic [CODE_W-1:0] code_t;
  localparam code_t CHAR_PRINT_LOW  = 21'd32;
  localparam code_t CHAR_PRINT_HIGH = 21'd126;
  localparam code_t CHAR_UPPER_LOW  = 21'd160;

  function automatic logic is_printable(input code_t c);
    return ((c >= CHAR_PRINT_LOW) && (c <= CHAR_PRINT_HIGH)) || (c >= CHAR_UPPER_LOW);
  endfunction

endpackage

### hw/rtl/kbet_ram.sv
module kbet_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/key_button_event_tracker_core.sv
// Key, character and mouse-button event filter. Key, character and button
// transactions are accepted one per cycle while the input is not stalled: a
// key's state is read from the key table memory at acceptance and written back
// from the s1 stage, with the previous update forwarded when two transactions
// hit the same key back to back, and a reported result is registered on the
// output as its transaction leaves the s1 stage. A clear transaction, and
// likewise the end of reset, starts a sweep that writes every key table entry
// back to released, one entry per cycle. Input is stalled during the sweep and
// while an accepted clear transaction is held in the s1 stage. Configuration
// writes are taken whenever reset is not asserted.
module key_button_event_tracker_core #(
  parameter int KEY_COUNT    = kbet_pkg::KEY_COUNT_DEF,
  parameter int BUTTON_COUNT = kbet_pkg::BUTTON_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kbet_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic                          cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    kind,
  input  logic [kbet_pkg::CODE_W-1:0]   code,
  input  logic                          action,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [1:0]                    source,
  output logic [kbet_pkg::CODE_W-1:0]   event_code,
  output logic                          event_action
);

  localparam int IDX_W = $clog2(KEY_COUNT);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_COUNT - 1);
  localparam kbet_pkg::code_t KEY_LIMIT = kbet_pkg::CODE_W'(KEY_COUNT);
  localparam kbet_pkg::code_t BUTTON_LIMIT = kbet_pkg::CODE_W'(BUTTON_COUNT);

  logic sticky_keys, sticky_buttons, repeat_enable;
  logic key_report_enable, char_report_enable, button_report_enable;

  logic              accept;
  logic              s1_valid, s1_go, s1_action, s1_key_ok;
  kbet_pkg::kind_t   s1_kind;
  kbet_pkg::code_t   s1_code;
  logic [IDX_W-1:0]  s1_idx;

  logic              clr_active;
  logic [IDX_W-1:0]  clr_idx;

  logic              fwd_valid;
  logic [IDX_W-1:0]  fwd_addr;
  kbet_pkg::kstate_t fwd_data;

  kbet_pkg::code_t   previous_char;

  kbet_pkg::kstate_t rd_data, cur_state, key_wdata, ram_wdata;
  logic              key_we, ram_we, emit;
  logic [IDX_W-1:0]  ram_waddr;

  always_ff @(posedge clk) begin
    if (rst) begin
      sticky_keys          <= 1'b0;
      sticky_buttons       <= 1'b0;
      repeat_enable        <= 1'b0;
      key_report_enable    <= 1'b0;
      char_report_enable   <= 1'b0;
      button_report_enable <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kbet_pkg::CFG_STICKY_KEYS:    sticky_keys          <= cfg_data;
        kbet_pkg::CFG_STICKY_BUTTONS: sticky_buttons       <= cfg_data;
        kbet_pkg::CFG_REPEAT_ENABLE:  repeat_enable        <= cfg_data;
        kbet_pkg::CFG_KEY_REPORT:     key_report_enable    <= cfg_data;
        kbet_pkg::CFG_CHAR_REPORT:    char_report_enable   <= cfg_data;
        kbet_pkg::CFG_BUTTON_REPORT:  button_report_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s1_go      = s1_valid && (!result_valid || !result_stall);
  assign item_stall = clr_active ||
                      (s1_valid && (!s1_go || (s1_kind == kbet_pkg::KIND_CLEAR)));
  assign accept     = item_valid && !item_stall;

  assign cur_state = (fwd_valid && (fwd_addr == s1_idx)) ? fwd_data : rd_data;

  always_comb begin
    key_we    = 1'b0;
    key_wdata = kbet_pkg::ST_RELEASED;
    emit      = 1'b0;
    unique case (s1_kind)
      kbet_pkg::KIND_KEY: begin
        if (s1_key_ok && (s1_action || (cur_state == kbet_pkg::ST_PRESSED))) begin
          key_we = s1_go;
          if (!s1_action && sticky_keys) begin
            key_wdata = kbet_pkg::ST_STUCK;
          end else begin
            key_wdata = s1_action ? kbet_pkg::ST_PRESSED : kbet_pkg::ST_RELEASED;
          end
          emit = key_report_enable && (repeat_enable || !s1_action ||
                                       (cur_state != kbet_pkg::ST_PRESSED));
        end
      end
      kbet_pkg::KIND_CHAR: begin
        if (kbet_pkg::is_printable(s1_code)) begin
          emit = char_report_enable &&
                 (repeat_enable || !s1_action || (previous_char != s1_code));
        end
      end
      kbet_pkg::KIND_BUTTON: begin
        emit = button_report_enable && (s1_code < BUTTON_LIMIT);
      end
      default: ;
    endcase
  end

  assign ram_we    = clr_active || key_we;
  assign ram_waddr = clr_active ? clr_idx : s1_idx;
  assign ram_wdata = clr_active ? kbet_pkg::ST_RELEASED : key_wdata;

  kbet_ram #(
    .WIDTH ($bits(kbet_pkg::kstate_t)),
    .DEPTH (KEY_COUNT)
  ) u_key_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (code[IDX_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else if (accept) begin
      s1_valid  <= 1'b1;
      fwd_valid <= key_we;
    end else if (s1_go) begin
      s1_valid  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind   <= kind;
      s1_code   <= code;
      s1_action <= action;
      s1_idx    <= code[IDX_W-1:0];
      s1_key_ok <= code < KEY_LIMIT;
      fwd_addr  <= s1_idx;
      fwd_data  <= key_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active    <= 1'b1;
      clr_idx       <= '0;
      previous_char <= '0;
    end else begin
      if (clr_active) begin
        if (clr_idx == LAST_IDX) begin
          clr_active <= 1'b0;
        end else begin
          clr_idx <= clr_idx + 1'b1;
        end
      end
      if (s1_go && (s1_kind == kbet_pkg::KIND_CLEAR)) begin
        clr_active    <= 1'b1;
        clr_idx       <= '0;
        previous_char <= '0;
      end else if (s1_go && (s1_kind == kbet_pkg::KIND_CHAR) &&
                   kbet_pkg::is_printable(s1_code)) begin
        previous_char <= s1_action ? s1_code : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_go && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      source       <= s1_kind;
      event_code   <= s1_code;
      event_action <= s1_action;
    end
  end

endmodule

### hw/rtl/kbet_checker.sv
`include "key_button_event_tracker_core_assert.svh"

module kbet_checker #(
  parameter int KEY_COUNT = kbet_pkg::KEY_COUNT_DEF
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        item_valid,
  input logic                        item_stall,
  input logic [1:0]                  kind,
  input logic                        result_valid,
  input logic                        result_stall,
  input logic [1:0]                  source,
  input logic [kbet_pkg::CODE_W-1:0] event_code,
  input logic                        event_action
);

  localparam kbet_pkg::code_t KEY_LIMIT = kbet_pkg::CODE_W'(KEY_COUNT);

  `KBET_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(source) && $stable(event_code) && $stable(event_action))
  `KBET_ASSERT_IMPLY(a_source_legal, result_valid, source != kbet_pkg::KIND_CLEAR)
  `KBET_ASSERT_NEXT(a_clear_stalls, item_valid && !item_stall && (kind == kbet_pkg::KIND_CLEAR), item_stall)
  `KBET_ASSERT_IMPLY(a_reset_sweep, $past(rst), item_stall)
  `KBET_ASSERT_IMPLY(a_key_in_table, result_valid && (source == kbet_pkg::KIND_KEY), event_code < KEY_LIMIT)

endmodule

bind key_button_event_tracker_core kbet_checker #(
  .KEY_COUNT (KEY_COUNT)
) u_kbet_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .kind         (kind),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .source       (source),
  .event_code   (event_code),
  .event_action (event_action)
);
